// ===== hdl/assert_macros.svh =====
// Assertion helpers for the receive window controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked on every rising edge while out of reset.
`define ASSERT_CLK(label, clock, reset, prop) \
  label: assert property (@(posedge clock) disable iff (reset) prop) \
    else $error("assertion failed");

// Expression that must never be true while out of reset.
`define ASSERT_NEVER(label, clock, reset, expr) \
  label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clock, reset, prop)
`define ASSERT_NEVER(label, clock, reset, expr)

`endif

`endif

// ===== hdl/ecn_rwc_pkg.sv =====
package ecn_rwc_pkg;

  // Gain of the alpha moving average is 2^-GAIN_SHIFT.
  localparam int GAIN_SHIFT = 4;
  localparam logic [3:0] MAX_SHIFT = 4'd14;

  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SEGMENT_SIZE   = 2'd0,
    REG_WEIGHT_SCALED  = 2'd1,
    REG_WINDOW_SHIFT   = 2'd2,
    REG_INITIAL_WINDOW = 2'd3
  } cfg_reg_t;

  localparam logic [15:0] SEGMENT_SIZE_RESET   = 16'd1460;
  localparam logic [15:0] WEIGHT_SCALED_RESET  = 16'd0;
  localparam logic [3:0]  WINDOW_SHIFT_RESET   = 4'd0;
  localparam logic [31:0] INITIAL_WINDOW_RESET = 32'd65535;

  typedef struct packed {
    logic        mode;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [15:0] marked_ratio;
  } ecn_in_t;

  typedef struct packed {
    logic [15:0] advertised_window;
    logic [31:0] window_bytes;
    logic [15:0] alpha_value;
  } ecn_out_t;

  localparam logic MODE_SENT = 1'b0;
  localparam logic MODE_ACK  = 1'b1;

  // Serial-number compare: a is after b when a - b lies in 1 .. 2^31-1.
  function automatic logic seq_after(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 32'd0) && !d[31];
  endfunction

  function automatic logic [15:0] advertise(input logic [31:0] window,
                                            input logic [3:0]  shift);
    logic [3:0]  sh;
    logic [31:0] w;
    sh = (shift > MAX_SHIFT) ? MAX_SHIFT : shift;
    w  = window >> sh;
    return (|w[31:16]) ? 16'hFFFF : w[15:0];
  endfunction

endpackage

// ===== hdl/ecn_receive_window_controller.sv =====
// Channel  Dir  Handshake              Beat
// -------  ---  ---------------------  ------------------------------------------
// in       in   in_valid / in_ready    mode, seq_number, ack_number, marked_ratio
// out      out  out_valid / out_ready  advertised_window, window_bytes, alpha_value
// cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// One beat per clock while out is not stalled; out_valid follows the input register stage.
// Input register -> alpha update, one 32x18 multiply for the window cut -> output register.
// The growth increment (weight * segment size / 256) is registered from the config registers.
// rst (synchronous) clears flow state and loads the register reset values.
// A stalled out beat does not block intake until the input register also fills.
module ecn_receive_window_controller #(
  parameter int GAIN_SHIFT = ecn_rwc_pkg::GAIN_SHIFT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  ecn_rwc_pkg::ecn_in_t                 in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output ecn_rwc_pkg::ecn_out_t                out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ecn_rwc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [31:0]                          cfg_data
);
  import ecn_rwc_pkg::*;

  `include "assert_macros.svh"

  localparam int ALPHA_SUM_W = 16 + GAIN_SHIFT + 1;

  // config registers
  logic [15:0] segment_size;
  logic [15:0] weight_scaled;
  logic [3:0]  window_shift;
  logic [23:0] grow_inc;

  // flow state
  logic [31:0] high_seq;
  logic [31:0] alpha_gate_seq;
  logic [31:0] window_gate_seq;
  logic [15:0] alpha_estimate;
  logic [31:0] recv_window;

  // pipeline
  ecn_in_t     in_q;
  logic        in_valid_q;
  logic [31:0] out_window;
  logic [15:0] out_alpha;
  logic        advance;
  logic        cfg_fire;

  logic                   alpha_gate;
  logic [ALPHA_SUM_W-1:0] alpha_sum;
  logic [15:0]            alpha_next;
  logic                   window_cut;
  logic [17:0]            cut_factor;
  logic [49:0]            cut_prod;
  logic [32:0]            grow_sum;
  logic [31:0]            window_next;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign advance   = in_valid_q && (!out_valid || out_ready);
  assign in_ready  = !in_valid_q || advance;

  always_comb begin
    alpha_gate = seq_after(in_q.ack_number, alpha_gate_seq);
    // alpha * (2^G - 1) + ratio, then drop G bits
    alpha_sum  = ({{(ALPHA_SUM_W-16-GAIN_SHIFT){1'b0}}, alpha_estimate, {GAIN_SHIFT{1'b0}}})
               - {{(ALPHA_SUM_W-16){1'b0}}, alpha_estimate}
               + {{(ALPHA_SUM_W-16){1'b0}}, in_q.marked_ratio};
    alpha_next = alpha_gate ? alpha_sum[GAIN_SHIFT +: 16] : alpha_estimate;

    window_cut = (alpha_next != 16'd0) && seq_after(in_q.ack_number, window_gate_seq);
    cut_factor = 18'h20000 - {2'b00, alpha_next};
    cut_prod   = {18'd0, recv_window} * {32'd0, cut_factor};
    grow_sum   = {1'b0, recv_window} + {9'd0, grow_inc};

    if (window_cut) begin
      window_next = cut_prod[48:17];
    end else if (grow_sum[32]) begin
      window_next = 32'hFFFF_FFFF;
    end else begin
      window_next = grow_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    grow_inc <= 24'(({16'd0, weight_scaled} * {16'd0, segment_size}) >> 8);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (in_q.mode == MODE_ACK) begin
        out_window <= window_next;
        out_alpha  <= alpha_next;
      end else begin
        out_window <= recv_window;
        out_alpha  <= alpha_estimate;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_size    <= SEGMENT_SIZE_RESET;
      weight_scaled   <= WEIGHT_SCALED_RESET;
      window_shift    <= WINDOW_SHIFT_RESET;
      high_seq        <= 32'd0;
      alpha_gate_seq  <= 32'd0;
      window_gate_seq <= 32'd0;
      alpha_estimate  <= 16'd0;
      recv_window     <= INITIAL_WINDOW_RESET;
    end else begin
      if (advance) begin
        if (in_q.mode == MODE_SENT) begin
          high_seq <= in_q.seq_number;
        end else begin
          if (alpha_gate) begin
            alpha_gate_seq <= high_seq;
          end
          if (window_cut) begin
            window_gate_seq <= high_seq;
          end
          alpha_estimate <= alpha_next;
          recv_window    <= window_next;
        end
      end
      if (cfg_fire) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_SEGMENT_SIZE:   segment_size  <= cfg_data[15:0];
          REG_WEIGHT_SCALED:  weight_scaled <= cfg_data[15:0];
          REG_WINDOW_SHIFT:   window_shift  <= cfg_data[3:0];
          REG_INITIAL_WINDOW: recv_window   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    out_data.advertised_window = advertise(out_window, window_shift);
    out_data.window_bytes      = out_window;
    out_data.alpha_value       = out_alpha;
  end

  `ASSERT_CLK(a_window_holds, clk, rst,
    (!advance && !(cfg_fire && cfg_index == REG_INITIAL_WINDOW)) |=> $stable(recv_window))
  `ASSERT_NEVER(a_stall_cause, clk, rst,
    !in_ready && !(in_valid_q && out_valid && !out_ready))
  `ASSERT_CLK(a_sent_keeps_alpha, clk, rst,
    (advance && in_q.mode == MODE_SENT) |=> ($stable(alpha_estimate) && $stable(alpha_gate_seq)))

endmodule
